[rtl/osort_pkg.sv]
// ----------------------------------------------------------------------------
// osort_pkg: shared types for the odd-even transposition sorter
// Item structs for both channels and the control word sent to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package osort_pkg;

  localparam int unsigned DataW = 32;

  // input item: one element of the set
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } in_item_t;

  // result item: one sorted element
  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    end_of_set;
    logic                    overflow;
  } out_item_t;

  // control broadcast along the cell chain
  typedef struct packed {
    logic shift;      // move every value one cell toward cell 0
    logic sort;       // run one compare-exchange phase
    logic odd_phase;  // 0: pairs (0,1),(2,3)..  1: pairs (1,2),(3,4)..
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/osort_cell.sv]
// ----------------------------------------------------------------------------
// osort_cell: one element slot of the sorting chain
// Holds one value and its valid flag; loads, shifts toward the head, or does
// its half of a compare-exchange with the neighbor chosen by the phase.
// ----------------------------------------------------------------------------
`default_nettype none

module osort_cell #(
  parameter bit ODD_POS = 1'b0
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  osort_pkg::cell_ctrl_t         ctrl_i,
  input  wire                           load_i,
  input  wire signed [osort_pkg::DataW-1:0] load_value_i,
  input  wire signed [osort_pkg::DataW-1:0] left_value_i,
  input  wire                           left_valid_i,
  input  wire signed [osort_pkg::DataW-1:0] right_value_i,
  input  wire                           right_valid_i,
  output logic signed [osort_pkg::DataW-1:0] value_o,
  output logic                          valid_o
);

  logic signed [osort_pkg::DataW-1:0] value_q, value_d;
  logic                               valid_q, valid_d;
  logic                               left_role;

  // this cell is the lower slot of its pair when parities match
  assign left_role = (ODD_POS == ctrl_i.odd_phase);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (load_i) begin
      value_d = load_value_i;
      valid_d = 1'b1;
    end else if (ctrl_i.shift) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.sort && valid_q) begin
      if (left_role) begin
        // keep the smaller of the pair
        if (right_valid_i && (value_q > right_value_i)) value_d = right_value_i;
      end else begin
        // keep the larger of the pair
        if (left_valid_i && (left_value_i > value_q)) value_d = left_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

[rtl/odd_even_transposition_sorter.sv]
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter: chain-of-cells ascending sorter
// A set of n elements loads at one item per cycle, then sorts with one
// compare-exchange phase per cycle across all cells, then emits one result per
// cycle from cell 0 while out_stall_i is low, as the chain shifts toward it.
// The input stalls while the set sorts and drains, so a new set is taken only
// after the last result of the previous one has been accepted.
// Reset clears state, counters and valid flags; cell values stay unreset.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_even_transposition_sorter #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  osort_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output osort_pkg::out_item_t  out_item_o
);

  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] phase_q, phase_d;
  logic            ovf_q, ovf_d;
  logic            in_acc, out_acc, full;
  osort_pkg::cell_ctrl_t ctrl;

  logic signed [osort_pkg::DataW-1:0] cell_val [MAX_ELEMENTS];
  logic                               cell_vld [MAX_ELEMENTS];

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign full        = (cnt_q == CntW'(MAX_ELEMENTS));

  // chain control
  assign ctrl.shift     = out_acc;
  assign ctrl.sort      = (state_q == ST_SORT);
  assign ctrl.odd_phase = phase_q[0];

  // sequencer: load, sort phases, drain
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) ovf_d = 1'b1;
          else      cnt_d = cnt_q + CntW'(1);
          if (in_item_i.last) begin
            state_d = ST_SORT;
            phase_d = '0;
          end
        end
      end
      ST_SORT: begin
        phase_d = phase_q + CntW'(1);
        if (phase_q == cnt_q - CntW'(1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          cnt_d = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_d = ST_LOAD;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      phase_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      ovf_q   <= ovf_d;
    end
  end

  // cell chain; cell 0 is the head that feeds the output
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic signed [osort_pkg::DataW-1:0] lval, rval;
    logic                               lvld, rvld, ld;

    if (i == 0) begin : g_head
      assign lval = '0;
      assign lvld = 1'b0;
    end else begin : g_mid_l
      assign lval = cell_val[i-1];
      assign lvld = cell_vld[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rval = cell_val[i+1];
      assign rvld = cell_vld[i+1];
    end

    assign ld = in_acc && !full && (cnt_q == CntW'(i));

    osort_cell #(
      .ODD_POS (1'(i % 2))
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .load_i        (ld),
      .load_value_i  (in_item_i.value),
      .left_value_i  (lval),
      .left_valid_i  (lvld),
      .right_value_i (rval),
      .right_valid_i (rvld),
      .value_o       (cell_val[i]),
      .valid_o       (cell_vld[i])
    );
  end

  // result item straight from the head cell
  assign out_item_o.sorted_value = cell_val[0];
  assign out_item_o.end_of_set   = (cnt_q == CntW'(1));
  assign out_item_o.overflow     = ovf_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cell_vld[0] && (cnt_q != '0))
    else $error("result offered from an empty chain");

  a_last_sorts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item_i.last |=> (state_q == ST_SORT) && (phase_q == '0))
    else $error("last item did not start the sort");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_item_o.end_of_set |=> !cell_vld[0] && (cnt_q == '0))
    else $error("chain not empty after final result");

endmodule

`default_nettype wire
